[hw/rtl/pixel_value_reclassifier_core_assert.svh]
// Assertion macros used by the pixel value reclassifier core.
`ifndef PIXEL_VALUE_RECLASSIFIER_CORE_ASSERT_SVH
`define PIXEL_VALUE_RECLASSIFIER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define PVR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("pvr assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define PVR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("pvr assertion failed");

`else

`define PVR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define PVR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/pvr_pkg.sv]
// Package of types, codes and defaults for the pixel value reclassifier.
package pvr_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_TABLE_DEPTH = 128;
  localparam int unsigned DEF_PIXEL_WIDTH = 32;

  // Fixed field widths
  localparam int unsigned ENTRY_IDX_W = 7;
  localparam int unsigned MODE_W      = 7;
  localparam int unsigned TBL_CNT_W   = 8;
  localparam int unsigned CFG_IDX_W   = 3;

  // Priority encoder group size (first level of the tree)
  localparam int unsigned GRP_SIZE = 16;
  localparam int unsigned GRP_IW   = 4;

  // Mode register fields
  localparam int unsigned MODE_OP_LSB = 2;
  localparam int unsigned MODE_ND_BIT = 5;
  localparam int unsigned MODE_OT_BIT = 6;

  localparam logic [1:0] METHOD_SINGLE = 2'd0;
  localparam logic [1:0] METHOD_RANGE  = 2'd1;

  // Single operators
  localparam logic [2:0] OP_EQ = 3'd0;
  localparam logic [2:0] OP_LT = 3'd1;
  localparam logic [2:0] OP_LE = 3'd2;
  localparam logic [2:0] OP_GE = 3'd3;
  localparam logic [2:0] OP_GT = 3'd4;

  // Range operators
  localparam logic [2:0] RNG_INCL = 3'd0;
  localparam logic [2:0] RNG_EXCL = 3'd1;

  // Table end rules
  localparam logic [2:0] TBL_GE_LT = 3'd0;
  localparam logic [2:0] TBL_GE_LE = 3'd1;
  localparam logic [2:0] TBL_GT_LE = 3'd2;
  localparam logic [2:0] TBL_GT_LT = 3'd3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE          = 3'd0,
    CFG_BOUND_LOW     = 3'd1,
    CFG_BOUND_HIGH    = 3'd2,
    CFG_HIT_VALUE     = 3'd3,
    CFG_NODATA_MARKER = 3'd4,
    CFG_NODATA_REPL   = 3'd5,
    CFG_OTHERS_REPL   = 3'd6,
    CFG_TABLE_ENTRIES = 3'd7
  } cfg_reg_e;

  // Origin of a result value
  typedef enum logic [1:0] {
    SRC_HIT    = 2'd0,
    SRC_NODATA = 2'd1,
    SRC_OTHERS = 2'd2,
    SRC_PASS   = 2'd3
  } src_e;

endpackage

[hw/rtl/pixel_value_reclassifier_core.sv]
// Pixel value reclassifier: single, range and table methods over a pixel stream.
//
// One beat enters per cycle while the output is not held; a classify beat passes
// four pipeline stages plus the output register before it leaves; a table write beat
// travels the same pipeline and leaves nothing. The depth is set by the table
// path: every table entry is compared with the pixel in parallel, a two-level
// registered priority encoder picks the first hit, and the hit code is read
// from a code RAM through its registered read port. Table bounds sit in flops,
// codes in the RAM; entries read before they are written give undefined codes.
// There is no clearing pass after reset. The whole pipeline holds while a
// result waits at the output, so nothing is lost or repeated under stall.
// s_axis_tuser_i carries func (1 = table write). Configuration must be written by the user
// only while the block is idle; the block itself does not enforce this.
module pixel_value_reclassifier_core #(
  parameter int unsigned TABLE_DEPTH = pvr_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned PIXEL_WIDTH = pvr_pkg::DEF_PIXEL_WIDTH,
  localparam int unsigned S_DW = ((4 * PIXEL_WIDTH + pvr_pkg::ENTRY_IDX_W + 7) / 8) * 8,
  localparam int unsigned M_DW = ((PIXEL_WIDTH + pvr_pkg::ENTRY_IDX_W + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port
  input  logic                           cfg_we_i,
  input  logic [pvr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [PIXEL_WIDTH-1:0]         cfg_data_i,
  // Input stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata: pixel_value, entry_index, entry_low, entry_high, entry_code, zero pad
  input  logic [S_DW-1:0]                s_axis_tdata_i,
  // tuser: func
  input  logic                           s_axis_tuser_i,
  // Output stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // tdata: result_value, hit_index, zero pad
  output logic [M_DW-1:0]                m_axis_tdata_o,
  // tuser: result_source
  output logic [1:0]                     m_axis_tuser_o
);

  import pvr_pkg::*;

  localparam int unsigned P      = PIXEL_WIDTH;
  localparam int unsigned IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned NGRP   = (TABLE_DEPTH + GRP_SIZE - 1) / GRP_SIZE;
  localparam int unsigned PAD_D  = NGRP * GRP_SIZE;
  localparam int unsigned OFF_IDX  = P;
  localparam int unsigned OFF_LO   = P + ENTRY_IDX_W;
  localparam int unsigned OFF_HI   = 2 * P + ENTRY_IDX_W;
  localparam int unsigned OFF_CODE = 3 * P + ENTRY_IDX_W;
  localparam int unsigned M_USED   = P + ENTRY_IDX_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [MODE_W-1:0]    mode_q;
  logic signed [P-1:0]  bound_low_q, bound_high_q, hit_value_q;
  logic signed [P-1:0]  nodata_marker_q, nodata_repl_q, others_repl_q;
  logic [TBL_CNT_W-1:0] table_entries_q;

  // Write the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q          <= '0;
      bound_low_q     <= '0;
      bound_high_q    <= P'(10);
      hit_value_q     <= P'(1);
      nodata_marker_q <= '0;
      nodata_repl_q   <= '0;
      others_repl_q   <= '0;
      table_entries_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_MODE:          mode_q          <= cfg_data_i[MODE_W-1:0];
        CFG_BOUND_LOW:     bound_low_q     <= cfg_data_i;
        CFG_BOUND_HIGH:    bound_high_q    <= cfg_data_i;
        CFG_HIT_VALUE:     hit_value_q     <= cfg_data_i;
        CFG_NODATA_MARKER: nodata_marker_q <= cfg_data_i;
        CFG_NODATA_REPL:   nodata_repl_q   <= cfg_data_i;
        CFG_OTHERS_REPL:   others_repl_q   <= cfg_data_i;
        CFG_TABLE_ENTRIES: table_entries_q <= cfg_data_i[TBL_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [1:0] method;
  logic [2:0] op;
  logic       is_table, nd_en, ot_en;

  assign method   = mode_q[1:0];
  assign op       = mode_q[MODE_OP_LSB +: 3];
  assign is_table = method[1];
  assign nd_en    = mode_q[MODE_ND_BIT];
  assign ot_en    = mode_q[MODE_OT_BIT];

  // ---------------------------------------------------------------------------
  // Pipeline control: every stage moves together unless the output is held
  // ---------------------------------------------------------------------------
  logic advance;
  logic in_acc;
  logic m_valid_q;

  assign advance         = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = advance;
  assign in_acc          = s_axis_tvalid_i && advance;

  // Unpack the input beat
  logic                   in_func;
  logic [P-1:0]           in_pix;
  logic [ENTRY_IDX_W-1:0] in_idx;
  logic [P-1:0]           in_lo, in_hi, in_code;

  assign in_func = s_axis_tuser_i;
  assign in_pix  = s_axis_tdata_i[0 +: P];
  assign in_idx  = s_axis_tdata_i[OFF_IDX +: ENTRY_IDX_W];
  assign in_lo   = s_axis_tdata_i[OFF_LO +: P];
  assign in_hi   = s_axis_tdata_i[OFF_HI +: P];
  assign in_code = s_axis_tdata_i[OFF_CODE +: P];

  // ---------------------------------------------------------------------------
  // Table bounds: written when the write beat is taken, compared in stage 1
  // ---------------------------------------------------------------------------
  logic signed [P-1:0] tbl_lo_q [TABLE_DEPTH];
  logic signed [P-1:0] tbl_hi_q [TABLE_DEPTH];

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_bounds
    always_ff @(posedge clk_i) begin
      if (in_acc && in_func && (32'(in_idx) == k)) begin
        tbl_lo_q[k] <= in_lo;
        tbl_hi_q[k] <= in_hi;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: captured beat
  // ---------------------------------------------------------------------------
  logic                   v1_q;
  logic                   func1_q;
  logic signed [P-1:0]    pix1_q;
  logic [ENTRY_IDX_W-1:0] idx1_q;
  logic [P-1:0]           code1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (advance) begin
      v1_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      func1_q <= in_func;
      pix1_q  <= in_pix;
      idx1_q  <= in_idx;
      code1_q <= in_code;
    end
  end

  // Compare the pixel with every table entry and with the rule bounds
  logic [PAD_D-1:0] match1;
  logic             rule_hit1;
  logic             is_nd1;

  always_comb begin
    logic ge_lo, gt_lo, le_hi, lt_hi;
    match1 = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      ge_lo = pix1_q >= tbl_lo_q[k];
      gt_lo = pix1_q >  tbl_lo_q[k];
      le_hi = pix1_q <= tbl_hi_q[k];
      lt_hi = pix1_q <  tbl_hi_q[k];
      if (k < int'(table_entries_q)) begin
        case (op)
          TBL_GE_LT: match1[k] = ge_lo && lt_hi;
          TBL_GE_LE: match1[k] = ge_lo && le_hi;
          TBL_GT_LE: match1[k] = gt_lo && le_hi;
          TBL_GT_LT: match1[k] = gt_lo && lt_hi;
          default:   match1[k] = 1'b0;
        endcase
      end
    end
  end

  always_comb begin
    rule_hit1 = 1'b0;
    if (method == METHOD_SINGLE) begin
      case (op)
        OP_EQ:   rule_hit1 = pix1_q == bound_low_q;
        OP_LT:   rule_hit1 = pix1_q <  bound_low_q;
        OP_LE:   rule_hit1 = pix1_q <= bound_low_q;
        OP_GE:   rule_hit1 = pix1_q >= bound_low_q;
        OP_GT:   rule_hit1 = pix1_q >  bound_low_q;
        default: rule_hit1 = 1'b0;
      endcase
    end else if (method == METHOD_RANGE) begin
      case (op)
        RNG_INCL: rule_hit1 = (bound_low_q <= pix1_q) && (pix1_q <= bound_high_q);
        RNG_EXCL: rule_hit1 = (bound_low_q <  pix1_q) && (pix1_q <  bound_high_q);
        default:  rule_hit1 = 1'b0;
      endcase
    end
  end

  assign is_nd1 = pix1_q == nodata_marker_q;

  // ---------------------------------------------------------------------------
  // Stage 2: match vector, first level of the priority encoder
  // ---------------------------------------------------------------------------
  logic                   v2_q;
  logic                   func2_q;
  logic signed [P-1:0]    pix2_q;
  logic [ENTRY_IDX_W-1:0] idx2_q;
  logic [P-1:0]           code2_q;
  logic [PAD_D-1:0]       match2_q;
  logic                   rule_hit2_q, is_nd2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (advance) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      func2_q     <= func1_q;
      pix2_q      <= pix1_q;
      idx2_q      <= idx1_q;
      code2_q     <= code1_q;
      match2_q    <= match1;
      rule_hit2_q <= rule_hit1;
      is_nd2_q    <= is_nd1;
    end
  end

  // Find the first hit inside each group
  logic [NGRP-1:0]   grp_any2;
  logic [GRP_IW-1:0] grp_idx2 [NGRP];

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any2[g] = |match2_q[g*GRP_SIZE +: GRP_SIZE];
      grp_idx2[g] = '0;
      for (int b = GRP_SIZE - 1; b >= 0; b--) begin
        if (match2_q[g*GRP_SIZE + b]) begin
          grp_idx2[g] = GRP_IW'(b);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: group results, second level of the encoder, code RAM access
  // ---------------------------------------------------------------------------
  logic                   v3_q;
  logic                   func3_q;
  logic signed [P-1:0]    pix3_q;
  logic [ENTRY_IDX_W-1:0] idx3_q;
  logic [P-1:0]           code3_q;
  logic [NGRP-1:0]        grp_any3_q;
  logic [GRP_IW-1:0]      grp_idx3_q [NGRP];
  logic                   rule_hit3_q, is_nd3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (advance) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      func3_q     <= func2_q;
      pix3_q      <= pix2_q;
      idx3_q      <= idx2_q;
      code3_q     <= code2_q;
      grp_any3_q  <= grp_any2;
      grp_idx3_q  <= grp_idx2;
      rule_hit3_q <= rule_hit2_q;
      is_nd3_q    <= is_nd2_q;
    end
  end

  // Pick the first group that hit
  logic             thit3;
  logic [IDX_W-1:0] hidx3;

  always_comb begin
    logic [31:0] sel;
    sel = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any3_q[g]) begin
        sel = 32'(g * GRP_SIZE) + 32'(grp_idx3_q[g]);
      end
    end
    thit3 = |grp_any3_q;
    hidx3 = sel[IDX_W-1:0];
  end

  // Write codes in step with the reads, so each beat sees the table in order
  logic        ram_we;
  logic [31:0] idx3_ext;
  logic [P-1:0] code_rd;

  assign idx3_ext = 32'(idx3_q);
  assign ram_we   = advance && v3_q && func3_q && (idx3_ext < TABLE_DEPTH);

  pvr_ram #(
    .WIDTH (P),
    .DEPTH (TABLE_DEPTH)
  ) u_code_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (idx3_ext[IDX_W-1:0]),
    .wr_data_i (code3_q),
    .rd_en_i   (advance),
    .rd_addr_i (hidx3),
    .rd_data_o (code_rd)
  );

  // ---------------------------------------------------------------------------
  // Stage 4: resolve the result
  // ---------------------------------------------------------------------------
  logic                v4_q;
  logic                func4_q;
  logic signed [P-1:0] pix4_q;
  logic                thit4_q;
  logic [IDX_W-1:0]    hidx4_q;
  logic                rule_hit4_q, is_nd4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (advance) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      func4_q     <= func3_q;
      pix4_q      <= pix3_q;
      thit4_q     <= thit3;
      hidx4_q     <= hidx3;
      rule_hit4_q <= rule_hit3_q;
      is_nd4_q    <= is_nd3_q;
    end
  end

  logic [P-1:0]           res_val;
  src_e                   res_src;
  logic [ENTRY_IDX_W-1:0] res_hit;

  always_comb begin
    logic [31:0] hidx_ext;
    hidx_ext = 32'(hidx4_q);
    res_val  = pix4_q;
    res_src  = SRC_PASS;
    res_hit  = '0;
    if (is_table && thit4_q) begin
      res_val = code_rd;
      res_src = SRC_HIT;
      res_hit = hidx_ext[ENTRY_IDX_W-1:0];
    end else if (nd_en && is_nd4_q) begin
      res_val = nodata_repl_q;
      res_src = SRC_NODATA;
    end else if (!is_table && rule_hit4_q) begin
      res_val = hit_value_q;
      res_src = SRC_HIT;
    end else if (ot_en && !is_nd4_q) begin
      res_val = others_repl_q;
      res_src = SRC_OTHERS;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: hold the beat until taken
  // ---------------------------------------------------------------------------
  logic [P-1:0]           m_val_q;
  src_e                   m_src_q;
  logic [ENTRY_IDX_W-1:0] m_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (advance) begin
      m_valid_q <= v4_q && !func4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      m_val_q <= res_val;
      m_src_q <= res_src;
      m_hit_q <= res_hit;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_src_q;

  if (M_DW > M_USED) begin : g_pad
    assign m_axis_tdata_o = {{(M_DW - M_USED){1'b0}}, m_hit_q, m_val_q};
  end else begin : g_nopad
    assign m_axis_tdata_o = {m_hit_q, m_val_q};
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`include "pixel_value_reclassifier_core_assert.svh"

  `PVR_ASSERT_IMPL(a_nodata_needs_enable, clk_i, rst_ni,
    m_valid_q && (m_src_q == SRC_NODATA), nd_en)
  `PVR_ASSERT_IMPL(a_others_needs_enable, clk_i, rst_ni,
    m_valid_q && (m_src_q == SRC_OTHERS), ot_en)
  `PVR_ASSERT_IMPL(a_rule_hit_index_zero, clk_i, rst_ni,
    m_valid_q && !is_table, m_hit_q == '0)
  `PVR_ASSERT_IMPL(a_table_hit_in_use, clk_i, rst_ni,
    m_valid_q && is_table && (m_src_q == SRC_HIT), {1'b0, m_hit_q} < table_entries_q)
  `PVR_ASSERT_NEXT(a_hit_reaches_stage4, clk_i, rst_ni,
    advance && v3_q && thit3, v4_q && thit4_q && (hidx4_q == $past(hidx3)))

endmodule

[hw/rtl/pvr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pvr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
